// ===== hw/rtl/utdq_pkg.sv =====
// Shared opcodes, status and finish codes, controller states and cell control for the task deque.
`timescale 1ns / 1ps

package utdq_pkg;

  // Operation codes carried on the input beat.
  localparam logic [2:0] OP_PUSH_BACK   = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT  = 3'd1;
  localparam logic [2:0] OP_TAKE_FRONT  = 3'd2;
  localparam logic [2:0] OP_MARK_ADD    = 3'd3;
  localparam logic [2:0] OP_MARK_REMOVE = 3'd4;
  localparam logic [2:0] OP_ERASE       = 3'd5;
  localparam logic [2:0] OP_ERASE_ALL   = 3'd6;

  // Response status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_REPLACED  = 3'd1;
  localparam logic [2:0] ST_PUSHED    = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND = 3'd6;

  // Finish codes in notifications.
  localparam logic [2:0] FC_NONE      = 3'd0;
  localparam logic [2:0] FC_CANCELLED = 3'd1;
  localparam logic [2:0] FC_PUSHED    = 3'd2;
  localparam logic [2:0] FC_REPLACED  = 3'd3;

  // Result kinds.
  localparam logic KIND_NOTICE   = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MATCH,
    S_PICK,
    S_N1,
    S_N2,
    S_ACT,
    S_INS,
    S_TAKE,
    S_CLR,
    S_RESP
  } state_t;

  // Per-cell control: load a new entry, rewrite payload and notifier,
  // take the right neighbor (toward the back), take the left neighbor.
  typedef struct packed {
    logic load;
    logic repl;
    logic shl;
    logic shr;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/utdq_cell.sv =====
// One deque slot: holds an entry, compares its id and trades entries with its neighbors.
`timescale 1ns / 1ps

module utdq_cell #(
  parameter int ID_BITS      = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  utdq_pkg::cell_ctl_t     ctl,
  input  logic [ID_BITS-1:0]      key,
  input  logic [ID_BITS-1:0]      new_id,
  input  logic [PAYLOAD_BITS-1:0] new_pay,
  input  logic                    new_mark,
  input  logic                    new_nt,
  input  logic [ID_BITS-1:0]      lf_id,
  input  logic [PAYLOAD_BITS-1:0] lf_pay,
  input  logic                    lf_mark,
  input  logic                    lf_nt,
  input  logic [ID_BITS-1:0]      rt_id,
  input  logic [PAYLOAD_BITS-1:0] rt_pay,
  input  logic                    rt_mark,
  input  logic                    rt_nt,
  output logic [ID_BITS-1:0]      id,
  output logic [PAYLOAD_BITS-1:0] pay,
  output logic                    mark,
  output logic                    nt,
  output logic                    match
);

  logic [ID_BITS-1:0]      id_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic                    mark_r;
  logic                    nt_r;

  // Entry storage; priority is load, rewrite, shift toward front, shift toward back.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id_r   <= new_id;
      pay_r  <= new_pay;
      mark_r <= new_mark;
      nt_r   <= new_nt;
    end else if (ctl.repl) begin
      pay_r <= new_pay;
      nt_r  <= new_nt;
    end else if (ctl.shl) begin
      id_r   <= rt_id;
      pay_r  <= rt_pay;
      mark_r <= rt_mark;
      nt_r   <= rt_nt;
    end else if (ctl.shr) begin
      id_r   <= lf_id;
      pay_r  <= lf_pay;
      mark_r <= lf_mark;
      nt_r   <= lf_nt;
    end
  end

  assign id    = id_r;
  assign pay   = pay_r;
  assign mark  = mark_r;
  assign nt    = nt_r;
  assign match = (id_r == key);

endmodule

// ===== hw/rtl/uid_task_deque_with_cancel_marks.sv =====
// Top level of the task deque: controller, result register and the row of entry cells.
`timescale 1ns / 1ps

// Bounded deque of tasks keyed by unique ids, with cancel marks, held in a row
// of QUEUE_DEPTH cells with the front in cell 0. One input beat is one
// operation; it returns zero or more notification beats and then one response
// beat with last set. An id lookup compares in every cell, then picks the
// first hit. It is followed by two notification slots, whether or not they
// emit, then neighbor shifting for removal, then insertion, then loading of
// the response. Take front and erase all shift the row one entry per cycle
// while the output slot is free: take front pops until a task comes out,
// erase all until the row is empty. An unused opcode goes straight to the
// response. A new beat is taken only when the previous response has been
// loaded.
module uid_task_deque_with_cancel_marks #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int ID_BITS      = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_task_id,
  input  logic        in_replace_allowed,
  input  logic [31:0] in_work_payload,
  input  logic        in_wants_notice,
  input  logic [2:0]  in_given_finish,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [15:0] out_subject_id,
  output logic [2:0]  out_finish_code,
  output logic [2:0]  out_status,
  output logic [31:0] out_taken_payload,
  output logic        out_taken_has_notice,
  output logic [4:0]  out_occupancy,
  output logic [4:0]  out_removed_count,
  output logic        out_last
);

  localparam int D     = QUEUE_DEPTH;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  utdq_pkg::state_t state_r, state_nxt;

  // Captured operation.
  logic [2:0]              op_r, op_nxt;
  logic [ID_BITS-1:0]      key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic                    nt_r, nt_nxt;
  logic                    repl_r, repl_nxt;
  logic [2:0]              given_r, given_nxt;

  // Deque bookkeeping.
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ID_BITS-1:0] ctr_r, ctr_nxt;

  // Lookup results.
  logic [D-1:0] match_r, match_nxt;
  logic [D-1:0] first_r, first_nxt;
  logic [D-1:0] ge_r, ge_nxt;

  // Planned steps of the operation.
  logic       n1_en_r, n1_en_nxt;
  logic [2:0] n1_fc_r, n1_fc_nxt;
  logic       n2_en_r, n2_en_nxt;
  logic       rm_r, rm_nxt;
  logic       rep_r, rep_nxt;
  logic       ins_r, ins_nxt;
  logic       insf_r, insf_nxt;

  // Response fields.
  logic [2:0]              st_r, st_nxt;
  logic [ID_BITS-1:0]      subj_r, subj_nxt;
  logic [PAYLOAD_BITS-1:0] tpay_r, tpay_nxt;
  logic                    tnt_r, tnt_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic        o_kind_r;
  logic [15:0] o_subj_r;
  logic [2:0]  o_fc_r;
  logic [2:0]  o_st_r;
  logic [31:0] o_pay_r;
  logic        o_tnt_r;
  logic [4:0]  o_occ_r;
  logic [4:0]  o_rem_r;
  logic        o_last_r;

  // Beat being loaded into the output register.
  logic                    emit;
  logic                    e_kind;
  logic [ID_BITS-1:0]      e_id;
  logic [2:0]              e_fc;
  logic [2:0]              e_st;
  logic [PAYLOAD_BITS-1:0] e_pay;
  logic                    e_tnt;
  logic [CNT_W-1:0]        e_occ;
  logic [CNT_W-1:0]        e_rem;
  logic                    e_last;
  logic [63:0]             e_id_w, e_pay_w, e_occ_w, e_rem_w;

  // Cell row.
  utdq_pkg::cell_ctl_t     ctl [D];
  logic [ID_BITS-1:0]      c_id [D];
  logic [PAYLOAD_BITS-1:0] c_pay [D];
  logic [D-1:0]            c_mark;
  logic [D-1:0]            c_nt;
  logic [D-1:0]            c_match;
  logic [ID_BITS-1:0]      new_id;
  logic [PAYLOAD_BITS-1:0] new_pay;
  logic                    new_mark;
  logic                    new_nt;

  // Misc combinational values.
  logic                    slot_free;
  logic [63:0]             in_id_w, in_pay_w;
  logic [ID_BITS-1:0]      id_in;
  logic [PAYLOAD_BITS-1:0] pay_in;
  logic [ID_BITS-1:0]      ctr_inc;
  logic [D-1:0]            first_c;
  logic                    hit_c, smark_c, snt_c;
  logic                    is_push_in;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == utdq_pkg::S_IDLE);

  // Input fields at the internal widths.
  assign in_id_w  = {48'b0, in_task_id};
  assign in_pay_w = {32'b0, in_work_payload};
  assign id_in    = in_id_w[ID_BITS-1:0];
  assign pay_in   = in_pay_w[PAYLOAD_BITS-1:0];
  assign ctr_inc  = ctr_r + 1'b1;
  assign is_push_in = (in_opcode == utdq_pkg::OP_PUSH_BACK) ||
                      (in_opcode == utdq_pkg::OP_PUSH_FRONT);

  // First matching cell and its flags.
  assign first_c = match_r & (~match_r + 1'b1);
  assign hit_c   = |match_r;
  assign smark_c = |(first_c & c_mark);
  assign snt_c   = |(first_c & c_nt);

  // Data offered to a cell that loads or rewrites an entry.
  assign new_id   = key_r;
  assign new_mark = (op_r == utdq_pkg::OP_MARK_ADD);
  assign new_pay  = (op_r == utdq_pkg::OP_MARK_ADD) ? '0 : pay_r;
  assign new_nt   = (op_r == utdq_pkg::OP_MARK_ADD) ? 1'b1 : nt_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      utdq_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            utdq_pkg::OP_TAKE_FRONT: state_nxt = utdq_pkg::S_TAKE;
            utdq_pkg::OP_ERASE_ALL:  state_nxt = utdq_pkg::S_CLR;
            utdq_pkg::OP_PUSH_BACK, utdq_pkg::OP_PUSH_FRONT, utdq_pkg::OP_MARK_ADD,
            utdq_pkg::OP_MARK_REMOVE, utdq_pkg::OP_ERASE: state_nxt = utdq_pkg::S_MATCH;
            default: state_nxt = utdq_pkg::S_RESP;
          endcase
        end
      end
      utdq_pkg::S_MATCH: state_nxt = utdq_pkg::S_PICK;
      utdq_pkg::S_PICK:  state_nxt = utdq_pkg::S_N1;
      utdq_pkg::S_N1: begin
        if (!n1_en_r || slot_free) state_nxt = utdq_pkg::S_N2;
      end
      utdq_pkg::S_N2: begin
        if (!n2_en_r || slot_free) state_nxt = utdq_pkg::S_ACT;
      end
      utdq_pkg::S_ACT: state_nxt = utdq_pkg::S_INS;
      utdq_pkg::S_INS: state_nxt = utdq_pkg::S_RESP;
      utdq_pkg::S_TAKE: begin
        if (count_r == '0) state_nxt = utdq_pkg::S_RESP;
        else if (slot_free && !c_mark[0]) state_nxt = utdq_pkg::S_RESP;
      end
      utdq_pkg::S_CLR: begin
        if (count_r == '0) state_nxt = utdq_pkg::S_RESP;
      end
      utdq_pkg::S_RESP: begin
        if (slot_free) state_nxt = utdq_pkg::S_IDLE;
      end
      default: state_nxt = utdq_pkg::S_IDLE;
    endcase
  end

  // Datapath and cell control per state.
  always_comb begin
    op_nxt    = op_r;
    key_nxt   = key_r;
    pay_nxt   = pay_r;
    nt_nxt    = nt_r;
    repl_nxt  = repl_r;
    given_nxt = given_r;
    count_nxt = count_r;
    ctr_nxt   = ctr_r;
    match_nxt = match_r;
    first_nxt = first_r;
    ge_nxt    = ge_r;
    n1_en_nxt = n1_en_r;
    n1_fc_nxt = n1_fc_r;
    n2_en_nxt = n2_en_r;
    rm_nxt    = rm_r;
    rep_nxt   = rep_r;
    ins_nxt   = ins_r;
    insf_nxt  = insf_r;
    st_nxt    = st_r;
    subj_nxt  = subj_r;
    tpay_nxt  = tpay_r;
    tnt_nxt   = tnt_r;
    rem_nxt   = rem_r;
    emit      = 1'b0;
    e_kind    = utdq_pkg::KIND_NOTICE;
    e_id      = key_r;
    e_fc      = utdq_pkg::FC_NONE;
    e_st      = utdq_pkg::ST_OK;
    e_pay     = '0;
    e_tnt     = 1'b0;
    e_occ     = '0;
    e_rem     = '0;
    e_last    = 1'b0;
    for (int i = 0; i < D; i++) ctl[i] = '0;

    unique case (state_r)
      utdq_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          key_nxt   = id_in;
          pay_nxt   = pay_in;
          nt_nxt    = in_wants_notice;
          repl_nxt  = in_replace_allowed;
          given_nxt = in_given_finish;
          st_nxt    = (in_opcode == utdq_pkg::OP_TAKE_FRONT) ? utdq_pkg::ST_EMPTY
                                                             : utdq_pkg::ST_OK;
          subj_nxt  = '0;
          tpay_nxt  = '0;
          tnt_nxt   = 1'b0;
          rem_nxt   = (in_opcode == utdq_pkg::OP_ERASE_ALL) ? count_r : '0;
          // A push with id zero takes a fresh id; the counter skips zero.
          if (is_push_in && id_in == '0) begin
            key_nxt = ctr_r;
            ctr_nxt = (ctr_inc == '0) ? ID_BITS'(1) : ctr_inc;
          end
        end
      end

      // Every live cell compares its id with the key.
      utdq_pkg::S_MATCH: begin
        for (int i = 0; i < D; i++) match_nxt[i] = c_match[i] && (CNT_W'(i) < count_r);
      end

      // Pick the first hit and plan notifications and row updates.
      utdq_pkg::S_PICK: begin
        first_nxt = first_c;
        ge_nxt    = ~(first_c - 1'b1);
        n1_en_nxt = 1'b0;
        n1_fc_nxt = utdq_pkg::FC_CANCELLED;
        n2_en_nxt = 1'b0;
        rm_nxt    = 1'b0;
        rep_nxt   = 1'b0;
        ins_nxt   = 1'b0;
        insf_nxt  = 1'b0;
        case (op_r)
          utdq_pkg::OP_PUSH_BACK, utdq_pkg::OP_PUSH_FRONT: begin
            if (hit_c && smark_c) begin
              n1_en_nxt = nt_r;
              n2_en_nxt = snt_c;
              rm_nxt    = 1'b1;
              st_nxt    = utdq_pkg::ST_CANCELLED;
            end else if (hit_c && !repl_r) begin
              n1_en_nxt = nt_r;
              n1_fc_nxt = utdq_pkg::FC_PUSHED;
              st_nxt    = utdq_pkg::ST_PUSHED;
            end else if (hit_c) begin
              n1_en_nxt = snt_c;
              n1_fc_nxt = utdq_pkg::FC_REPLACED;
              rep_nxt   = 1'b1;
              subj_nxt  = key_r;
              st_nxt    = utdq_pkg::ST_REPLACED;
            end else begin
              ins_nxt  = 1'b1;
              insf_nxt = (op_r == utdq_pkg::OP_PUSH_FRONT);
            end
          end
          utdq_pkg::OP_MARK_ADD: begin
            n1_en_nxt = hit_c && snt_c;
            rm_nxt    = hit_c;
            ins_nxt   = 1'b1;
          end
          default: begin
            if (!hit_c || (op_r == utdq_pkg::OP_MARK_REMOVE && !smark_c)) begin
              st_nxt = utdq_pkg::ST_NOT_FOUND;
            end else begin
              n1_en_nxt = snt_c;
              n1_fc_nxt = given_r;
              rm_nxt    = 1'b1;
              subj_nxt  = key_r;
            end
          end
        endcase
      end

      utdq_pkg::S_N1: begin
        if (n1_en_r && slot_free) begin
          emit = 1'b1;
          e_fc = n1_fc_r;
        end
      end

      // The second notice only ever reports the cancelled mark.
      utdq_pkg::S_N2: begin
        if (n2_en_r && slot_free) begin
          emit = 1'b1;
          e_fc = utdq_pkg::FC_CANCELLED;
        end
      end

      // Close the gap at the hit, or rewrite the hit in place.
      utdq_pkg::S_ACT: begin
        if (rm_r) begin
          for (int i = 0; i < D; i++) ctl[i].shl = ge_r[i];
          count_nxt = count_r - 1'b1;
        end
        if (rep_r) begin
          for (int i = 0; i < D; i++) ctl[i].repl = first_r[i];
        end
      end

      // Insert at the front (whole row shifts back) or at the first free cell behind the tail.
      utdq_pkg::S_INS: begin
        if (ins_r) begin
          if (count_r >= CNT_W'(D)) begin
            st_nxt   = utdq_pkg::ST_FULL;
            subj_nxt = '0;
          end else begin
            subj_nxt  = key_r;
            count_nxt = count_r + 1'b1;
            for (int i = 0; i < D; i++) begin
              if (insf_r) begin
                ctl[i].load = (i == 0);
                ctl[i].shr  = (i != 0);
              end else begin
                ctl[i].load = (CNT_W'(i) == count_r);
              end
            end
          end
        end
      end

      // Pop the front once a cycle while the output slot is free, until a task comes out or the row is empty.
      utdq_pkg::S_TAKE: begin
        if (count_r != '0 && slot_free) begin
          for (int i = 0; i < D; i++) ctl[i].shl = 1'b1;
          count_nxt = count_r - 1'b1;
          if (c_mark[0]) begin
            emit = c_nt[0];
            e_id = c_id[0];
            e_fc = utdq_pkg::FC_CANCELLED;
          end else begin
            subj_nxt = c_id[0];
            tpay_nxt = c_pay[0];
            tnt_nxt  = c_nt[0];
            st_nxt   = utdq_pkg::ST_OK;
          end
        end
      end

      // Drain the row from the front, notifying as entries leave.
      utdq_pkg::S_CLR: begin
        if (count_r != '0 && slot_free) begin
          for (int i = 0; i < D; i++) ctl[i].shl = 1'b1;
          count_nxt = count_r - 1'b1;
          emit = c_nt[0];
          e_id = c_id[0];
          e_fc = given_r;
        end
      end

      utdq_pkg::S_RESP: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_kind = utdq_pkg::KIND_RESPONSE;
          e_id   = subj_r;
          e_st   = st_r;
          e_pay  = tpay_r;
          e_tnt  = tnt_r;
          e_occ  = count_r;
          e_rem  = rem_r;
          e_last = 1'b1;
        end
      end

      default: ;
    endcase
  end

  // Widen the outgoing beat to port widths.
  always_comb begin
    e_id_w  = '0;
    e_pay_w = '0;
    e_occ_w = '0;
    e_rem_w = '0;
    e_id_w[ID_BITS-1:0]       = e_id;
    e_pay_w[PAYLOAD_BITS-1:0] = e_pay;
    e_occ_w[CNT_W-1:0]        = e_occ;
    e_rem_w[CNT_W-1:0]        = e_rem;
  end

  assign out_valid_nxt = emit || (out_valid_r && !out_ready);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= utdq_pkg::S_IDLE;
      count_r     <= '0;
      ctr_r       <= ID_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operation and plan registers.
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    pay_r   <= pay_nxt;
    nt_r    <= nt_nxt;
    repl_r  <= repl_nxt;
    given_r <= given_nxt;
    match_r <= match_nxt;
    first_r <= first_nxt;
    ge_r    <= ge_nxt;
    n1_en_r <= n1_en_nxt;
    n1_fc_r <= n1_fc_nxt;
    n2_en_r <= n2_en_nxt;
    rm_r    <= rm_nxt;
    rep_r   <= rep_nxt;
    ins_r   <= ins_nxt;
    insf_r  <= insf_nxt;
    st_r    <= st_nxt;
    subj_r  <= subj_nxt;
    tpay_r  <= tpay_nxt;
    tnt_r   <= tnt_nxt;
    rem_r   <= rem_nxt;
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (emit) begin
      o_kind_r <= e_kind;
      o_subj_r <= e_id_w[15:0];
      o_fc_r   <= e_fc;
      o_st_r   <= e_st;
      o_pay_r  <= e_pay_w[31:0];
      o_tnt_r  <= e_tnt;
      o_occ_r  <= e_occ_w[4:0];
      o_rem_r  <= e_rem_w[4:0];
      o_last_r <= e_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_kind      = o_kind_r;
  assign out_subject_id       = o_subj_r;
  assign out_finish_code      = o_fc_r;
  assign out_status           = o_st_r;
  assign out_taken_payload    = o_pay_r;
  assign out_taken_has_notice = o_tnt_r;
  assign out_occupancy        = o_occ_r;
  assign out_removed_count    = o_rem_r;
  assign out_last             = o_last_r;

  // Row of cells, front at index 0.
  for (genvar g = 0; g < D; g++) begin : g_cell
    logic [ID_BITS-1:0]      lf_id, rt_id;
    logic [PAYLOAD_BITS-1:0] lf_pay, rt_pay;
    logic                    lf_mark, rt_mark, lf_nt, rt_nt;

    if (g == 0) begin : g_lf_edge
      assign lf_id   = '0;
      assign lf_pay  = '0;
      assign lf_mark = 1'b0;
      assign lf_nt   = 1'b0;
    end else begin : g_lf
      assign lf_id   = c_id[g-1];
      assign lf_pay  = c_pay[g-1];
      assign lf_mark = c_mark[g-1];
      assign lf_nt   = c_nt[g-1];
    end

    if (g == D - 1) begin : g_rt_edge
      assign rt_id   = '0;
      assign rt_pay  = '0;
      assign rt_mark = 1'b0;
      assign rt_nt   = 1'b0;
    end else begin : g_rt
      assign rt_id   = c_id[g+1];
      assign rt_pay  = c_pay[g+1];
      assign rt_mark = c_mark[g+1];
      assign rt_nt   = c_nt[g+1];
    end

    utdq_cell #(
      .ID_BITS      (ID_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl[g]),
      .key      (key_r),
      .new_id   (new_id),
      .new_pay  (new_pay),
      .new_mark (new_mark),
      .new_nt   (new_nt),
      .lf_id    (lf_id),
      .lf_pay   (lf_pay),
      .lf_mark  (lf_mark),
      .lf_nt    (lf_nt),
      .rt_id    (rt_id),
      .rt_pay   (rt_pay),
      .rt_mark  (rt_mark),
      .rt_nt    (rt_nt),
      .id       (c_id[g]),
      .pay      (c_pay[g]),
      .mark     (c_mark[g]),
      .nt       (c_nt[g]),
      .match    (c_match[g])
    );
  end

endmodule
